FILE: rtl/largest_prime_divisor_unit_macros.svh
// assertion macros for the largest prime divisor unit
`ifndef LARGEST_PRIME_DIVISOR_UNIT_MACROS_SVH
`define LARGEST_PRIME_DIVISOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define LPD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpd assertion failed");

// next-cycle implication, checked out of reset
`define LPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpd assertion failed");

`else

`define LPD_ASSERT_IMPL(label, ante, cons)
`define LPD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/lpd_pkg.sv
package lpd_pkg;

	// fixed field widths
	localparam int IN_WIDTH    = 48;
	localparam int PRIME_WIDTH = 47;
	localparam int COUNT_WIDTH = 4;

	// default magnitude width
	localparam int VALUE_WIDTH_DEF = 47;

	// status from the shared divider
	typedef struct packed {
		logic busy;
		logic done;
		logic rem_zero;
	} div_status_t;

endpackage

FILE: rtl/lpd_div.sv
module lpd_div #(
	parameter int VALUE_WIDTH = lpd_pkg::VALUE_WIDTH_DEF,
	parameter int DIV_WIDTH   = (lpd_pkg::VALUE_WIDTH_DEF + 1) / 2 + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_WIDTH-1:0]  dividend,
	input  logic [DIV_WIDTH-1:0]    divisor,
	output logic [VALUE_WIDTH-1:0]  quotient,
	output lpd_pkg::div_status_t    status
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] dq_q;
	logic [DIV_WIDTH-1:0]   rem_q;
	logic [DIV_WIDTH-1:0]   dvs_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [DIV_WIDTH:0]     trial;
	logic                   qbit;
	logic [DIV_WIDTH-1:0]   rem_next;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, dq_q[VALUE_WIDTH-1]};
		qbit  = (trial >= {1'b0, dvs_q});
		if (qbit) begin
			rem_next = DIV_WIDTH'(trial - {1'b0, dvs_q});
		end else begin
			rem_next = trial[DIV_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q   <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				dq_q  <= {dq_q[VALUE_WIDTH-2:0], qbit};
				rem_q <= rem_next;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				dq_q   <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
				cnt_q  <= CW'(VALUE_WIDTH);
				busy_q <= 1'b1;
			end
		end
	end

	assign quotient        = dq_q;
	assign status.busy     = busy_q;
	assign status.done     = done_q;
	assign status.rem_zero = (rem_q == '0);

endmodule

FILE: rtl/largest_prime_divisor_unit.sv
// largest prime divisor unit
// input channel: value (48-bit two's complement) on value_valid / value_ready.
// output channel: found, largest_prime, distinct_primes on result_valid / result_ready.
// one result transaction per input transaction, in order.
// the magnitude of value (low VALUE_WIDTH bits) is factored by trial division:
// first by 2, then by odd candidates while candidate squared <= cofactor.
// found is set when there are two or more distinct primes; largest_prime is then
// the biggest of them, else 0. distinct_primes always gives the count.
// each trial division runs on one shared restoring divider, and a candidate
// that fails then goes through the square check; the candidates tried run up
// to roughly sqrt(magnitude) / 2. zero and one skip the divider and go straight
// to the done state. value_ready is high only while the sequencer is idle: one
// transaction is worked at a time. the result sits in an output register; a new
// input may be taken while it waits. if the receiver stalls, the next result
// holds in the done state until the output register frees up, and value_ready
// stays low meanwhile. reset (arst_n low, asynchronous) drops result_valid and
// returns to idle.
`include "largest_prime_divisor_unit_macros.svh"

module largest_prime_divisor_unit #(
	parameter int VALUE_WIDTH = lpd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               value_valid,
	output logic                               value_ready,
	input  logic signed [lpd_pkg::IN_WIDTH-1:0] value,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic                               found,
	output logic [lpd_pkg::PRIME_WIDTH-1:0]    largest_prime,
	output logic [lpd_pkg::COUNT_WIDTH-1:0]    distinct_primes
);

	localparam int IW = lpd_pkg::IN_WIDTH;
	localparam int PW = lpd_pkg::PRIME_WIDTH;
	localparam int NW = lpd_pkg::COUNT_WIDTH;
	// candidate width: covers the first candidate whose square exceeds any cofactor
	localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
	// candidate squared
	localparam int SW = 2 * DW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_CHECK,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic [VALUE_WIDTH-1:0]   cof_q;       // running cofactor
	logic [VALUE_WIDTH-1:0]   largest_q;   // largest prime seen
	logic [DW-1:0]            cand_q;      // current candidate divisor
	logic [SW-1:0]            sq_q;        // candidate squared, kept by addition
	logic [NW-1:0]            count_q;     // distinct primes so far
	logic                     hit_q;       // current candidate already counted

	logic [IW-1:0]            mag_full;
	logic [VALUE_WIDTH-1:0]   mag;
	logic                     div_start;
	logic [VALUE_WIDTH-1:0]   div_quot;
	lpd_pkg::div_status_t     div_st;
	logic                     out_free;
	logic                     is_found;

	// magnitude, wrapped to the working width
	always_comb begin
		if (value[IW-1]) begin
			mag_full = IW'(~value) + IW'(1);
		end else begin
			mag_full = value;
		end
		mag = VALUE_WIDTH'(mag_full);
	end

	assign value_ready = (state_q == S_IDLE);
	assign div_start   = (state_q == S_START);
	assign out_free    = !result_valid || result_ready;
	assign is_found    = (count_q >= NW'(2));

	lpd_div #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DIV_WIDTH  (DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(cof_q),
		.divisor (cand_q),
		.quotient(div_quot),
		.status  (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cof_q           <= '0;
			largest_q       <= '0;
			cand_q          <= '0;
			sq_q            <= '0;
			count_q         <= '0;
			hit_q           <= 1'b0;
			result_valid    <= 1'b0;
			found           <= 1'b0;
			largest_prime   <= '0;
			distinct_primes <= '0;
		end else begin
			// output register drains on a taken transaction
			if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (value_valid) begin
						cof_q     <= mag;
						largest_q <= '0;
						count_q   <= '0;
						cand_q    <= DW'(2);
						sq_q      <= SW'(4);
						hit_q     <= 1'b0;
						// zero and one have no prime factors
						if (mag >= VALUE_WIDTH'(2)) begin
							state_q <= S_START;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_st.done) begin
						if (div_st.rem_zero) begin
							// divides: strip it and try again
							cof_q <= div_quot;
							if (!hit_q) begin
								count_q   <= count_q + NW'(1);
								largest_q <= VALUE_WIDTH'(cand_q);
								hit_q     <= 1'b1;
							end
							state_q <= S_START;
						end else begin
							// move to the next candidate: 2 -> 3, then odd steps
							hit_q <= 1'b0;
							if (cand_q == DW'(2)) begin
								cand_q <= DW'(3);
								sq_q   <= SW'(9);
							end else begin
								cand_q <= cand_q + DW'(2);
								sq_q   <= sq_q + SW'({cand_q, 2'b00}) + SW'(4);
							end
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (sq_q <= SW'(cof_q)) begin
						state_q <= S_START;
					end else begin
						// leftover cofactor above one is itself prime
						if (cof_q > VALUE_WIDTH'(1)) begin
							count_q   <= count_q + NW'(1);
							largest_q <= cof_q;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						result_valid    <= 1'b1;
						found           <= is_found;
						largest_prime   <= is_found ? PW'(largest_q) : '0;
						distinct_primes <= count_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the divider is never busy while a new transaction can come in
	`LPD_ASSERT_IMPL(a_idle_div, value_ready, !div_st.busy)
	// a started division is running in the next cycle
	`LPD_ASSERT_NEXT(a_div_runs, div_start, div_st.busy)
	// a result without found carries no prime
	`LPD_ASSERT_IMPL(a_no_prime, result_valid && !found, largest_prime == '0)
	// past the first candidate, candidates stay odd
	`LPD_ASSERT_IMPL(a_odd_cand, div_start && (cand_q != DW'(2)), cand_q[0])

endmodule
